>>> sv/sfx_pkg.sv
package sfx_pkg;

  localparam logic [7:0] FRAME_END = 8'h3B;
  localparam logic [7:0] CTRL_TOP  = 8'h1F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } sfx_state_e;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic start_read;
    logic load_out;
  } sfx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done;
    logic read_last;
    logic out_free;
  } sfx_sts_t;

endpackage

>>> sv/sfx_in_if.sv
interface sfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

>>> sv/sfx_out_if.sv
interface sfx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

>>> sv/sfx_ctrl.sv
module sfx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfx_pkg::sfx_sts_t sts_i,
  output sfx_pkg::sfx_cmd_t cmd_o
);
  import sfx_pkg::*;

  sfx_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i;
        if (in_valid_i && sts_i.frame_done) begin
          cmd_o.start_read = 1'b1;
          state_d          = ST_READ;
        end
      end
      // memory read address settles, data lands next cycle
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.read_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sfx_datapath.sv
module sfx_datapath #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  sfx_pkg::sfx_cmd_t cmd_i,
  output sfx_pkg::sfx_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        frame_byte_o,
  output logic              frame_last_o
);
  import sfx_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int RW = $clog2(MAX_FRAME_BYTES + 2);
  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam logic [CW-1:0] STORE_MAX = CW'(MAX_FRAME_BYTES);
  localparam logic [RW-1:0] RAW_MAX   = RW'(MAX_FRAME_BYTES);
  localparam logic [RW-1:0] RAW_SAT   = RW'(MAX_FRAME_BYTES + 1);

  logic [7:0]    mem [MAX_FRAME_BYTES];
  logic [7:0]    rdata_q;
  logic [CW-1:0] stored_q, stored_d;
  logic [RW-1:0] raw_q, raw_d, raw_inc;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] last_idx_q, last_idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          out_last_q;
  logic          is_end, is_ctrl, fits, wr_en;

  assign raw_inc = (raw_q < RAW_SAT) ? raw_q + RW'(1) : raw_q;
  assign is_end  = (data_byte_i == FRAME_END);
  assign is_ctrl = (data_byte_i <= CTRL_TOP);
  assign fits    = (raw_inc <= RAW_MAX) && (stored_q < STORE_MAX);
  assign wr_en   = cmd_i.take_byte && fits && (is_end || !is_ctrl || stored_q != '0);

  assign sts_o.frame_done = is_end && fits;
  assign sts_o.read_last  = (rd_ptr_q == last_idx_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    stored_d   = stored_q;
    raw_d      = raw_q;
    last_idx_d = last_idx_q;
    rd_ptr_d   = rd_ptr_q;
    if (cmd_i.take_byte) begin
      if (is_end) begin
        stored_d = '0;
        raw_d    = '0;
      end else begin
        raw_d = raw_inc;
        if (wr_en) begin
          stored_d = stored_q + CW'(1);
        end
      end
    end
    if (cmd_i.start_read) begin
      last_idx_d = stored_q[AW-1:0];
      rd_ptr_d   = '0;
    end else if (cmd_i.load_out) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q    <= '0;
      raw_q       <= '0;
      last_idx_q  <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stored_q    <= stored_d;
      raw_q       <= raw_d;
      last_idx_q  <= last_idx_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[stored_q[AW-1:0]] <= data_byte_i;
    end
    rdata_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q <= rdata_q;
      out_last_q <= sts_o.read_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_last_o = out_last_q;

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= STORE_MAX) else $error("stored count past frame limit");
  a_raw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raw_q <= RAW_SAT) else $error("raw length past saturation");
  a_stored_le_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(stored_q) <= CW'(raw_q) || raw_q >= RAW_SAT)
    else $error("stored count exceeds raw length");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q) else $error("loaded result not shown");
  a_no_load_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

>>> sv/semicolon_frame_extractor_top.sv
// a frame's first byte goes to the read-data register after its semicolon transfer, then to
//   the output register once that is free; 1 input byte per cycle between frames; output
//   bytes are read one at a time through the frame store's registered read port (address,
//   then load); no input is taken during readout; a waiting result does not block input
// reset: asynchronous active low, clears counts, controller and output valid;
//   frame store contents are left as they are
module semicolon_frame_extractor_top #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sfx_in_if.sink   in_i,
  sfx_out_if.source out_o
);
  import sfx_pkg::*;

  sfx_cmd_t cmd;
  sfx_sts_t sts;

  // controller sequences the transfer of bytes in and the readout of frames
  sfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, frame store and output register
  sfx_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (in_i.data_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .frame_byte_o (out_o.frame_byte),
    .frame_last_o (out_o.frame_last)
  );

endmodule

>>> bench/tb_semicolon_frame_extractor_top.sv
`timescale 1ns / 1ps

module tb_semicolon_frame_extractor_top;
  import sfx_pkg::*;

  localparam int FRAME_MAX    = 64;
  localparam int TOTAL_BYTES  = 480;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_WAIT     = 13;
  localparam int REPORT_MAX   = 10;
  localparam int TYPED_NONE   = -1;

  // one row of the directed table: a byte sent reps times in a row; where typed_n
  // is not TYPED_NONE, the last of them must release exactly that many frame bytes
  typedef struct packed {
    logic [7:0] data;
    int         reps;
    int         typed_n;
  } stim_row_t;

  typedef struct {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_beat_t;

  localparam int DIRECTED_ROWS = 27;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // lone semicolon right after reset
    '{8'h3B, 1, 1},
    // leading control bytes at both ends of their range are dropped
    '{8'h00, 1, TYPED_NONE},
    '{8'h1F, 1, TYPED_NONE},
    '{8'hFF, 1, TYPED_NONE},
    '{8'h01, 1, TYPED_NONE},
    '{8'h3B, 1, 3},
    // smallest byte above the control range, top bit, interior control byte
    '{8'h20, 1, TYPED_NONE},
    '{8'h80, 1, TYPED_NONE},
    '{8'h7F, 1, TYPED_NONE},
    '{8'h1F, 1, TYPED_NONE},
    '{8'h3B, 1, 5},
    // frame filling the store exactly
    '{8'h41, 63, TYPED_NONE},
    '{8'h3B, 1, 64},
    // one byte over the limit: dropped without a trace
    '{8'h42, 64, TYPED_NONE},
    '{8'h3B, 1, 0},
    // dropped head bytes still count toward the raw length, at the limit
    '{8'h00, 62, TYPED_NONE},
    '{8'h5A, 1, TYPED_NONE},
    '{8'h3B, 1, 2},
    // same but one over, because of the head
    '{8'h1F, 63, TYPED_NONE},
    '{8'h5A, 1, TYPED_NONE},
    '{8'h3B, 1, 0},
    // raw length well past saturation
    '{8'hAA, 100, TYPED_NONE},
    '{8'h3B, 1, 0},
    // nothing but control bytes before the semicolon
    '{8'h10, 3, TYPED_NONE},
    '{8'h3B, 1, 1},
    // normal frame right after a frame that kept only its semicolon
    '{8'h55, 1, TYPED_NONE},
    '{8'h3B, 1, 2}
  };

  logic clk_i;
  logic rst_ni;

  sfx_in_if  in_ch ();
  sfx_out_if out_ch ();

  semicolon_frame_extractor_top #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor state: the frame being collected
  logic [7:0]  frame_mem [FRAME_MAX];
  int          stored_cnt;
  int          raw_len;
  frame_beat_t pending_frame_bytes [$];

  int fail_cnt;
  int bytes_sent;
  int cycle_cnt;
  bit in_burst;
  bit out_burst;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // feeds one received byte through the predictor; on an accepted semicolon the
  // whole stored frame is queued as expected output, returns how many bytes
  function automatic int extract_frame_bytes(input logic [7:0] b);
    int released;
    int k;
    released = 0;
    if (raw_len < FRAME_MAX + 1) raw_len++;
    if (b == FRAME_END) begin
      if (raw_len <= FRAME_MAX && stored_cnt < FRAME_MAX) begin
        frame_mem[stored_cnt] = b;
        stored_cnt++;
        for (k = 0; k < stored_cnt; k++) begin
          pending_frame_bytes.push_back('{frame_mem[k], k + 1 == stored_cnt});
        end
        released = stored_cnt;
      end
      stored_cnt = 0;
      raw_len    = 0;
    end else if (!(b <= CTRL_TOP && stored_cnt == 0)) begin
      // head control bytes only move raw_len, everything else is stored while it fits
      if (raw_len <= FRAME_MAX && stored_cnt < FRAME_MAX) begin
        frame_mem[stored_cnt] = b;
        stored_cnt++;
      end
    end
    return released;
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] v;
    if ($urandom_range(0, 5) == 0) begin
      v = 8'($urandom_range(0, 31));
    end else begin
      do v = 8'($urandom_range(0, 255)); while (v == FRAME_END);
    end
    return v;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_cnt < REPORT_MAX) $display("mismatch: %s", msg);
    fail_cnt++;
  endtask

  // one input transfer, after a random number of idle cycles
  task automatic send_byte(input logic [7:0] b, output int released);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    released = extract_frame_bytes(b);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    bytes_sent++;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
  endtask

  // leading control bytes, random body, then the semicolon
  task automatic send_frame(input int lead, input int body);
    int released;
    repeat (lead) send_byte(8'($urandom_range(0, 31)), released);
    repeat (body) send_byte(body_byte(), released);
    send_byte(FRAME_END, released);
  endtask

  // main sequence: reset, directed table, random traffic, drain
  initial begin
    int released;
    int i;
    int r;
    int pick;
    int lead;
    int body;
    int n;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    stored_cnt      = 0;
    raw_len         = 0;
    fail_cnt        = 0;
    bytes_sent      = 0;
    in_burst        = 1'b0;
    out_burst       = 1'b0;
    for (i = 0; i < FRAME_MAX; i++) frame_mem[i] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      released = 0;
      for (r = 0; r < DIRECTED[i].reps; r++) send_byte(DIRECTED[i].data, released);
      if (DIRECTED[i].typed_n != TYPED_NONE && released != DIRECTED[i].typed_n) begin
        note_failure($sformatf("row %0d: frame of %0d bytes predicted, %0d typed",
                               i, released, DIRECTED[i].typed_n));
      end
    end

    // random part fills up the byte budget: mostly well-formed frames,
    // some raw noise, some oversized frames
    while (bytes_sent < TOTAL_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        lead = $urandom_range(0, 3);
        if ($urandom_range(0, 11) == 0) body = int'($urandom_range(56, 70)) - lead;
        else body = $urandom_range(0, 8);
        send_frame(lead, body);
      end else if (pick < 90) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_byte(($urandom_range(0, 3) == 0) ? FRAME_END : 8'($urandom_range(0, 255)),
                    released);
        end
      end else begin
        send_frame($urandom_range(0, 5), $urandom_range(66, 80));
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_frame_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // output side: random stall before each transfer, then compare with the oldest expectation
  initial begin
    int stall;
    frame_beat_t exp_beat;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      if (pending_frame_bytes.size() == 0) begin
        note_failure($sformatf("unexpected frame byte %02h last %0b",
                               out_ch.frame_byte, out_ch.frame_last));
      end else begin
        exp_beat = pending_frame_bytes.pop_front();
        if (out_ch.frame_byte !== exp_beat.frame_byte) begin
          note_failure($sformatf("frame_byte expected %02h, got %02h",
                                 exp_beat.frame_byte, out_ch.frame_byte));
        end
        if (out_ch.frame_last !== exp_beat.frame_last) begin
          note_failure($sformatf("frame_last expected %0b, got %0b",
                                 exp_beat.frame_last, out_ch.frame_last));
        end
      end
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> semicolon_frame_extractor_top.f
sv/sfx_pkg.sv
sv/sfx_in_if.sv
sv/sfx_out_if.sv
sv/sfx_ctrl.sv
sv/sfx_datapath.sv
sv/semicolon_frame_extractor_top.sv
bench/tb_semicolon_frame_extractor_top.sv
